/* design/dpcr_pkg.sv */
// Shared types, widths and saturation helper for the disc pair collision pipeline.
package dpcr_pkg;

	// Widths derived from the fixed field formats (Q16.16 positions, Q8.8 radii)
	localparam int MIND_W     = 25;  // (ra + rb) << 8
	localparam int D2_W       = 51;  // dx^2 + dy^2 and sqrt working width
	localparam int Q_W        = 17;  // normal magnitude, at most 65536
	localparam int NUM_W      = 42;  // division numerator and remainder
	localparam int SQRT_STEPS = 25;
	localparam int DIV_STEPS  = 17;
	localparam int RST_W      = 17;
	localparam int SAT_W      = 37;

	typedef struct packed {
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] first_vel_x;
		logic signed [31:0] first_vel_y;
		logic [15:0]        first_radius;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] second_vel_x;
		logic signed [31:0] second_vel_y;
		logic [15:0]        second_radius;
	} dpcr_in_t;

	typedef struct packed {
		logic signed [31:0] new_first_pos_x;
		logic signed [31:0] new_first_pos_y;
		logic signed [31:0] new_first_vel_x;
		logic signed [31:0] new_first_vel_y;
		logic signed [31:0] new_second_pos_x;
		logic signed [31:0] new_second_pos_y;
		logic signed [31:0] new_second_vel_x;
		logic signed [31:0] new_second_vel_y;
		logic               collided;
	} dpcr_out_t;

	// Per-beat context that rides along the whole pipeline
	typedef struct packed {
		dpcr_in_t           pair;
		logic               hit;
		logic [MIND_W-1:0]  mind;
		logic               sx;
		logic               sy;
		logic [MIND_W-1:0]  adx;
		logic [MIND_W-1:0]  ady;
		logic signed [32:0] dvx;
		logic signed [32:0] dvy;
	} dpcr_ctx_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		if (v > 37'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -37'sd2147483648)
			return 32'sh80000000;
		else
			return $signed(v[31:0]);
	endfunction

endpackage

/* design/dpcr_front.sv */
// Front stages: differences, overlap test, squares and exact collision check.
module dpcr_front import dpcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             valid,
	input  dpcr_in_t         pair,
	output logic             valid_s3,
	output dpcr_ctx_t        ctx_s3,
	output logic [D2_W-1:0]  d2_s3
);

	logic signed [32:0] dx, dy;
	logic [32:0]        adx, ady;
	logic [16:0]        rsum;
	logic [MIND_W-1:0]  mind;
	dpcr_ctx_t          ctx_c;

	// Stage 1: exact 33-bit differences and box test
	always_comb begin
		dx = $signed({pair.second_pos_x[31], pair.second_pos_x})
			- $signed({pair.first_pos_x[31], pair.first_pos_x});
		dy = $signed({pair.second_pos_y[31], pair.second_pos_y})
			- $signed({pair.first_pos_y[31], pair.first_pos_y});
		adx = dx[32] ? $unsigned(-dx) : $unsigned(dx);
		ady = dy[32] ? $unsigned(-dy) : $unsigned(dy);
		rsum = {1'b0, pair.first_radius} + {1'b0, pair.second_radius};
		mind = {rsum, 8'd0};
		ctx_c.pair = pair;
		ctx_c.hit  = (adx < {8'd0, mind}) && (ady < {8'd0, mind});
		ctx_c.mind = mind;
		ctx_c.sx   = dx[32];
		ctx_c.sy   = dy[32];
		ctx_c.adx  = adx[MIND_W-1:0];
		ctx_c.ady  = ady[MIND_W-1:0];
		ctx_c.dvx  = $signed({pair.second_vel_x[31], pair.second_vel_x})
			- $signed({pair.first_vel_x[31], pair.first_vel_x});
		ctx_c.dvy  = $signed({pair.second_vel_y[31], pair.second_vel_y})
			- $signed({pair.first_vel_y[31], pair.first_vel_y});
	end

	logic               valid_s1, valid_s2;
	dpcr_ctx_t          ctx_s1, ctx_s2;
	logic [D2_W-2:0]    dx2_s2, dy2_s2, m2_s2;
	logic [D2_W-1:0]    d2;
	dpcr_ctx_t          ctx_c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 3 combine: exact distance-squared test
	assign d2 = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_comb begin
		ctx_c3     = ctx_s2;
		ctx_c3.hit = ctx_s2.hit && (d2 != '0) && (d2 < {1'b0, m2_s2});
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctx_s1     <= ctx_c;
			// Stage 2: squares
			ctx_s2     <= ctx_s1;
			dx2_s2     <= ctx_s1.adx * ctx_s1.adx;
			dy2_s2     <= ctx_s1.ady * ctx_s1.ady;
			m2_s2      <= ctx_s1.mind * ctx_s1.mind;
			ctx_s3     <= ctx_c3;
			d2_s3      <= d2;
		end
	end

endmodule

/* design/dpcr_sqrt.sv */
// Pipelined digit-by-digit floor square root, one result bit per stage.
module dpcr_sqrt import dpcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              valid,
	input  dpcr_ctx_t         ctx,
	input  logic [D2_W-1:0]   d2,
	output logic              valid_out,
	output dpcr_ctx_t         ctx_out,
	output logic [MIND_W-1:0] cdist
);

	logic              valid_s [0:SQRT_STEPS];
	dpcr_ctx_t         ctx_s   [0:SQRT_STEPS];
	logic [D2_W-1:0]   rem_s   [0:SQRT_STEPS];
	logic [D2_W-1:0]   root_s  [0:SQRT_STEPS];

	assign valid_s[0] = valid;
	assign ctx_s[0]   = ctx;
	assign rem_s[0]   = d2;
	assign root_s[0]  = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [D2_W-1:0] BIT = D2_W'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [D2_W-1:0] trial;
		assign trial = root_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[k+1] <= 1'b0;
			else if (advance)
				valid_s[k+1] <= valid_s[k];
		end

		// One compare-subtract per stage
		always_ff @(posedge clk) begin
			if (advance) begin
				ctx_s[k+1] <= ctx_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign valid_out = valid_s[SQRT_STEPS];
	assign ctx_out   = ctx_s[SQRT_STEPS];
	assign cdist     = root_s[SQRT_STEPS][MIND_W-1:0];

endmodule

/* design/dpcr_div.sv */
// Pipelined restoring division for the unit normal, one quotient bit per stage.
module dpcr_div import dpcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              valid,
	input  dpcr_ctx_t         ctx,
	input  logic [MIND_W-1:0] cdist,
	output logic              valid_out,
	output dpcr_ctx_t         ctx_out,
	output logic [MIND_W-1:0] overlap,
	output logic [Q_W-1:0]    qx,
	output logic [Q_W-1:0]    qy
);

	logic              valid_s [0:DIV_STEPS];
	dpcr_ctx_t         ctx_s   [0:DIV_STEPS];
	logic [MIND_W-1:0] cdist_s [0:DIV_STEPS];
	logic [MIND_W-1:0] ovl_s   [0:DIV_STEPS];
	logic [NUM_W-1:0]  remx_s  [0:DIV_STEPS];
	logic [NUM_W-1:0]  remy_s  [0:DIV_STEPS];
	logic [Q_W-1:0]    qx_s    [0:DIV_STEPS];
	logic [Q_W-1:0]    qy_s    [0:DIV_STEPS];

	assign valid_s[0] = valid;
	assign ctx_s[0]   = ctx;
	assign cdist_s[0] = cdist;
	assign ovl_s[0]   = ctx.mind - cdist;
	assign remx_s[0]  = NUM_W'({ctx.adx, 16'd0});
	assign remy_s[0]  = NUM_W'({ctx.ady, 16'd0});
	assign qx_s[0]    = '0;
	assign qy_s[0]    = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - k;
		logic [NUM_W-1:0] dsh;
		assign dsh = NUM_W'(cdist_s[k]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[k+1] <= 1'b0;
			else if (advance)
				valid_s[k+1] <= valid_s[k];
		end

		// x and y quotient bits side by side
		always_ff @(posedge clk) begin
			if (advance) begin
				ctx_s[k+1]   <= ctx_s[k];
				cdist_s[k+1] <= cdist_s[k];
				ovl_s[k+1]   <= ovl_s[k];
				if (remx_s[k] >= dsh) begin
					remx_s[k+1] <= remx_s[k] - dsh;
					qx_s[k+1]   <= qx_s[k] | (Q_W'(1) << SH);
				end else begin
					remx_s[k+1] <= remx_s[k];
					qx_s[k+1]   <= qx_s[k];
				end
				if (remy_s[k] >= dsh) begin
					remy_s[k+1] <= remy_s[k] - dsh;
					qy_s[k+1]   <= qy_s[k] | (Q_W'(1) << SH);
				end else begin
					remy_s[k+1] <= remy_s[k];
					qy_s[k+1]   <= qy_s[k];
				end
			end
		end
	end

	assign valid_out = valid_s[DIV_STEPS];
	assign ctx_out   = ctx_s[DIV_STEPS];
	assign overlap   = ovl_s[DIV_STEPS];
	assign qx        = qx_s[DIV_STEPS];
	assign qy        = qy_s[DIV_STEPS];

endmodule

/* design/dpcr_back.sv */
// Back stages: separation push, approach test, impulse and saturated result.
module dpcr_back import dpcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [RST_W-1:0]  restitution,
	input  logic              valid,
	input  dpcr_ctx_t         ctx,
	input  logic [MIND_W-1:0] overlap,
	input  logic [Q_W-1:0]    qx,
	input  logic [Q_W-1:0]    qy,
	output logic              valid_s5,
	output dpcr_out_t         result_s5
);

	logic signed [Q_W:0] nx, ny;
	assign nx = ctx.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign ny = ctx.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	dpcr_ctx_t           ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic [Q_W-1:0]      qx_s1, qy_s1, qx_s2, qy_s2, qx_s3, qy_s3;
	logic signed [50:0]  prodx_s1, prody_s1;
	logic [MIND_W-1:0]   pushx_s1, pushy_s1;
	logic [41:0]         pxp, pyp;

	assign pxp = qx * overlap;
	assign pyp = qy * overlap;

	// Stage 2 combine: approach speed and separated positions
	logic signed [51:0]    pdot;
	logic [51:0]           apdot;
	logic signed [SAT_W-1:0] spx, spy;
	assign pdot  = 52'(prodx_s1) + 52'(prody_s1);
	assign apdot = pdot[51] ? $unsigned(-pdot) : $unsigned(pdot);
	assign spx   = ctx_s1.sx ? -$signed({12'd0, pushx_s1}) : $signed({12'd0, pushx_s1});
	assign spy   = ctx_s1.sy ? -$signed({12'd0, pushy_s1}) : $signed({12'd0, pushy_s1});

	logic              neg_s2, neg_s3, neg_s4;
	logic [32:0]       vn_s2;
	logic signed [31:0] pos_s2 [0:3];
	logic signed [31:0] pos_s3 [0:3];
	logic signed [31:0] pos_s4 [0:3];
	logic [33:0]       j_s3;
	logic [34:0]       impx_s4, impy_s4;
	logic [50:0]       jp;
	logic [50:0]       ixp, iyp;

	assign jp  = vn_s2 * ({1'b0, restitution} + 18'd65536);
	assign ixp = j_s3 * qx_s3;
	assign iyp = j_s3 * qy_s3;

	// Stage 5 combine: signed impulse applied to velocities
	logic signed [SAT_W-1:0] ix, iy;
	logic                    kick;
	assign ix   = ctx_s4.sx ? -$signed({2'd0, impx_s4}) : $signed({2'd0, impx_s4});
	assign iy   = ctx_s4.sy ? -$signed({2'd0, impy_s4}) : $signed({2'd0, impy_s4});
	assign kick = ctx_s4.hit && neg_s4;

	function automatic logic signed [SAT_W-1:0] ext(input logic signed [31:0] v);
		return SAT_W'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// Stage 1: relative velocity products and push magnitudes
			ctx_s1   <= ctx;
			qx_s1    <= qx;
			qy_s1    <= qy;
			prodx_s1 <= ctx.dvx * nx;
			prody_s1 <= ctx.dvy * ny;
			pushx_s1 <= pxp[41:17];
			pushy_s1 <= pyp[41:17];
			// Stage 2
			ctx_s2   <= ctx_s1;
			qx_s2    <= qx_s1;
			qy_s2    <= qy_s1;
			neg_s2   <= pdot[51];
			vn_s2    <= apdot[48:16];
			if (ctx_s1.hit) begin
				pos_s2[0] <= sat32(ext(ctx_s1.pair.first_pos_x) - spx);
				pos_s2[1] <= sat32(ext(ctx_s1.pair.first_pos_y) - spy);
				pos_s2[2] <= sat32(ext(ctx_s1.pair.second_pos_x) + spx);
				pos_s2[3] <= sat32(ext(ctx_s1.pair.second_pos_y) + spy);
			end else begin
				pos_s2[0] <= ctx_s1.pair.first_pos_x;
				pos_s2[1] <= ctx_s1.pair.first_pos_y;
				pos_s2[2] <= ctx_s1.pair.second_pos_x;
				pos_s2[3] <= ctx_s1.pair.second_pos_y;
			end
			// Stage 3: restitution scale
			ctx_s3   <= ctx_s2;
			qx_s3    <= qx_s2;
			qy_s3    <= qy_s2;
			neg_s3   <= neg_s2;
			pos_s3   <= pos_s2;
			j_s3     <= jp[50:17];
			// Stage 4: impulse along the normal
			ctx_s4   <= ctx_s3;
			neg_s4   <= neg_s3;
			pos_s4   <= pos_s3;
			impx_s4  <= ixp[50:16];
			impy_s4  <= iyp[50:16];
			// Stage 5: output register
			result_s5.new_first_pos_x  <= pos_s4[0];
			result_s5.new_first_pos_y  <= pos_s4[1];
			result_s5.new_second_pos_x <= pos_s4[2];
			result_s5.new_second_pos_y <= pos_s4[3];
			result_s5.collided         <= ctx_s4.hit;
			if (kick) begin
				result_s5.new_first_vel_x  <= sat32(ext(ctx_s4.pair.first_vel_x) - ix);
				result_s5.new_first_vel_y  <= sat32(ext(ctx_s4.pair.first_vel_y) - iy);
				result_s5.new_second_vel_x <= sat32(ext(ctx_s4.pair.second_vel_x) + ix);
				result_s5.new_second_vel_y <= sat32(ext(ctx_s4.pair.second_vel_y) + iy);
			end else begin
				result_s5.new_first_vel_x  <= ctx_s4.pair.first_vel_x;
				result_s5.new_first_vel_y  <= ctx_s4.pair.first_vel_y;
				result_s5.new_second_vel_x <= ctx_s4.pair.second_vel_x;
				result_s5.new_second_vel_y <= ctx_s4.pair.second_vel_y;
			end
		end
	end

endmodule

/* design/disc_pair_collision_resolve_top.sv */
// Top level of the disc pair collision resolver: handshake, register and pipeline.
//
// Usage:
//   pair channel: one candidate disc pair per beat (pair_valid / pair_stall).
//   result channel: the updated pair plus a collided flag per beat
//   (result_valid / result_stall), in the order the pairs went in.
//   cfg_wr_en / cfg_wr_data write the Q1.16 restitution; write it only while
//   no beat is in flight.
// Pipeline: 3 front stages, 25 square root stages, 17 divide stages,
//   5 back stages.
// Throughput: one pair per cycle while not stalled; the square root and divider
//   are fully pipelined, one bit per stage.
// Reset: arst_n clears all valid bits and sets restitution to zero.
// Stall: when result_stall holds a waiting result, the whole pipeline
//   freezes and pair_stall goes high in the same cycle; nothing is lost.
module disc_pair_collision_resolve_top import dpcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pair_valid,
	output logic             pair_stall,
	input  dpcr_in_t         pair,
	output logic             result_valid,
	input  logic             result_stall,
	output dpcr_out_t        result,
	input  logic             cfg_wr_en,
	input  logic [RST_W-1:0] cfg_wr_data
);

	logic [RST_W-1:0] restitution_q;
	logic             advance;

	// Restitution register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			restitution_q <= '0;
		else if (cfg_wr_en)
			restitution_q <= cfg_wr_data;
	end

	// Global pipeline enable
	assign advance    = !(result_valid && result_stall);
	assign pair_stall = !advance;

	logic              fr_valid, sq_valid, dv_valid;
	dpcr_ctx_t         fr_ctx, sq_ctx, dv_ctx;
	logic [D2_W-1:0]   fr_d2;
	logic [MIND_W-1:0] sq_dist, dv_overlap;
	logic [Q_W-1:0]    dv_qx, dv_qy;

	dpcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid    (pair_valid),
		.pair     (pair),
		.valid_s3 (fr_valid),
		.ctx_s3   (fr_ctx),
		.d2_s3    (fr_d2)
	);

	dpcr_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid     (fr_valid),
		.ctx       (fr_ctx),
		.d2        (fr_d2),
		.valid_out (sq_valid),
		.ctx_out   (sq_ctx),
		.cdist     (sq_dist)
	);

	dpcr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid     (sq_valid),
		.ctx       (sq_ctx),
		.cdist     (sq_dist),
		.valid_out (dv_valid),
		.ctx_out   (dv_ctx),
		.overlap   (dv_overlap),
		.qx        (dv_qx),
		.qy        (dv_qy)
	);

	dpcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.restitution (restitution_q),
		.valid       (dv_valid),
		.ctx         (dv_ctx),
		.overlap     (dv_overlap),
		.qx          (dv_qx),
		.qy          (dv_qy),
		.valid_s5    (result_valid),
		.result_s5   (result)
	);

	// A colliding pair always has a nonzero distance
	a_dist_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && sq_ctx.hit |-> sq_dist != '0)
		else $error("collision with zero distance");

	// Normal components never exceed one
	a_normal_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && dv_ctx.hit |-> dv_qx <= 17'd65536 && dv_qy <= 17'd65536)
		else $error("normal component above one");

	// Overlap is positive on a collision
	a_overlap_pos: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && dv_ctx.hit |-> dv_overlap != '0)
		else $error("collision without overlap");

endmodule
